// File: design/adcc_pkg.sv
`default_nettype none

package adcc_pkg;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_MANUAL = 2'd0;
    localparam mode_t MODE_TRACK  = 2'd1;
    localparam mode_t MODE_SAR    = 2'd2;
    localparam mode_t MODE_RESET  = MODE_SAR;

    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam int  PADDR_W  = 3;
    localparam int  PDATA_W  = 32;
    localparam logic REG_MODE = 1'b0;

    typedef struct packed {
        logic       action;
        logic       comparator_high;
        logic [7:0] switch_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] dac_code;
        logic [7:0] led_pattern;
        logic       busy_res;
        logic       conversion_done;
    } result_t;

endpackage

`default_nettype wire

// File: design/adcc_if.sv
`default_nettype none

interface adcc_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic       comparator_high;
    logic [7:0] switch_byte;

    modport source (output valid, output action, output comparator_high,
                    output switch_byte, input ready);
    modport sink   (input valid, input action, input comparator_high,
                    input switch_byte, output ready);
endinterface

interface adcc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] dac_code;
    logic [7:0] led_pattern;
    logic       busy_res;
    logic       conversion_done;

    modport source (output valid, output dac_code, output led_pattern,
                    output busy_res, output conversion_done, input ready);
    modport sink   (input valid, input dac_code, input led_pattern,
                    input busy_res, input conversion_done, output ready);
endinterface

`default_nettype wire

// File: design/adcc_cfg.sv
`default_nettype none

module adcc_cfg
    import adcc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output mode_t                   mode
);

    mode_t mode_reg;
    mode_t mode_next;
    logic  hit;

    assign hit    = (paddr[2] == REG_MODE);
    assign pready = 1'b1;

    always_comb
    begin
        mode_next = mode_reg;
        if (psel && penable && pwrite && hit)
        begin
            mode_next = pwdata[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    assign prdata = hit ? {{(PDATA_W-2){1'b0}}, mode_reg} : '0;
    assign mode   = mode_reg;

endmodule

`default_nettype wire

// File: design/adcc_engine.sv
`default_nettype none

module adcc_engine
    import adcc_pkg::*;
#(
    parameter int DAC_BITS = 8
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire mode_t mode,
    input  wire logic  adv,
    input  wire item_t item,
    output result_t    res
);

    localparam int IDX_W = $clog2(DAC_BITS);
    localparam logic [IDX_W-1:0]    TOP_IDX = IDX_W'(DAC_BITS - 1);
    localparam logic [DAC_BITS-1:0] TOP_BIT = {1'b1, {(DAC_BITS-1){1'b0}}};
    localparam logic [DAC_BITS-1:0] ONE     = DAC_BITS'(1);

    logic [DAC_BITS-1:0] code_reg;
    logic [DAC_BITS-1:0] code_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic                run_reg;
    logic                run_next;
    result_t             res_reg;
    result_t             res_next;

    logic                done;
    logic                led_sw;
    logic [DAC_BITS-1:0] trial_cleared;
    logic [15:0]         code_ext;

    always_comb
    begin
        code_next     = code_reg;
        idx_next      = idx_reg;
        run_next      = run_reg;
        done          = 1'b0;
        led_sw        = 1'b0;
        trial_cleared = item.comparator_high ? (code_reg & ~(ONE << idx_reg)) : code_reg;

        if (item.action == ACT_START)
        begin
            case (mode)
                MODE_MANUAL:
                begin
                    code_next = ~DAC_BITS'(item.switch_byte);
                    run_next  = 1'b0;
                    done      = 1'b1;
                    led_sw    = 1'b1;
                end
                MODE_TRACK:
                begin
                    code_next = ONE;
                    idx_next  = '0;
                    run_next  = 1'b1;
                end
                MODE_SAR:
                begin
                    code_next = TOP_BIT;
                    idx_next  = TOP_IDX;
                    run_next  = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (run_reg)
        begin
            case (mode)
                MODE_TRACK:
                begin
                    if (item.comparator_high)
                    begin
                        code_next = code_reg - ONE;
                        run_next  = 1'b0;
                        done      = 1'b1;
                    end
                    else if (&code_reg)
                    begin
                        run_next = 1'b0;
                        done     = 1'b1;
                    end
                    else
                    begin
                        code_next = code_reg + ONE;
                    end
                end
                MODE_SAR:
                begin
                    if (idx_reg == '0)
                    begin
                        code_next = trial_cleared;
                        run_next  = 1'b0;
                        done      = 1'b1;
                    end
                    else
                    begin
                        idx_next  = idx_reg - IDX_W'(1);
                        code_next = trial_cleared | (ONE << (idx_reg - IDX_W'(1)));
                    end
                end
                default:
                begin
                    run_next = 1'b0;
                end
            endcase
        end

        code_ext                 = 16'(code_next);
        res_next.dac_code        = code_ext[7:0];
        res_next.led_pattern     = led_sw ? item.switch_byte : ~code_ext[7:0];
        res_next.busy_res        = run_next;
        res_next.conversion_done = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg <= '0;
            idx_reg  <= '0;
            run_reg  <= 1'b0;
        end
        else if (adv)
        begin
            code_reg <= code_next;
            idx_reg  <= idx_next;
            run_reg  <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

    a_busy_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> (res_reg.busy_res == run_reg))
        else $error("result busy flag disagrees with run state");

    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        adv && done |=> !run_reg)
        else $error("run still active after completion");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (idx_reg <= TOP_IDX))
        else $error("trial bit index out of range");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> !(res_reg.busy_res && res_reg.conversion_done))
        else $error("word flagged both busy and done");

endmodule

`default_nettype wire

// File: design/adc_conversion_controller.sv
// Channel  Dir  Word                                           Handshake
// in_ch    in   action, comparator_high, switch_byte[7:0]      valid/ready
// out_ch   out  dac_code[7:0], led_pattern[7:0], busy_res,     valid/ready
//               conversion_done
// apb      in   conversion_mode at byte address 0              psel/penable, pready=1
//
// One word per cycle sustained while out_ch does not stall; each word passes through
// the input register, then state update and the result register.
// The code/trial-index/run state loop closes through its own registers, so words may follow back to back.
// rst_n is asynchronous: code, trial index and run flag clear, mode returns to successive approx.
// While a result waits, the input register accepts only if it is empty; a stalled out_ch backs up one stage.
`default_nettype none

module adc_conversion_controller
    import adcc_pkg::*;
#(
    parameter int DAC_BITS = 8
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    adcc_in_if.sink                 in_ch,
    adcc_out_if.source              out_ch,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    mode_t   mode;
    logic    s1_valid_reg;
    logic    s1_valid_next;
    item_t   s1_item_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    adv;
    logic    take;
    result_t res;

    adcc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mode    (mode)
    );

    adcc_engine #(
        .DAC_BITS (DAC_BITS)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .mode  (mode),
        .adv   (adv),
        .item  (s1_item_reg),
        .res   (res)
    );

    assign adv         = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || adv;
    assign take        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_item_reg.action          <= in_ch.action;
            s1_item_reg.comparator_high <= in_ch.comparator_high;
            s1_item_reg.switch_byte     <= in_ch.switch_byte;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.dac_code        = res.dac_code;
    assign out_ch.led_pattern     = res.led_pattern;
    assign out_ch.busy_res        = res.busy_res;
    assign out_ch.conversion_done = res.conversion_done;

endmodule

`default_nettype wire

// File: bench/adcc_result_checker.sv
`timescale 1ns / 100ps

module adcc_result_checker
    import adcc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    adcc_in_if                      in_mon,
    adcc_out_if                     out_mon,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic               pready,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output int                      mismatches,
    output int                      outstanding
);

    localparam logic [PADDR_W-1:0] MODE_ADDR   = PADDR_W'(4 * REG_MODE);
    localparam logic [7:0]         SAR_FIRST   = 8'b1000_0000;
    localparam logic [7:0]         TRACK_FIRST = 8'b0000_0001;
    localparam logic [7:0]         CODE_FULL   = 8'hFF;
    localparam logic [2:0]         TOP_TRIAL   = 3'd7;

    mode_t      mode_shadow;
    logic [7:0] code_shadow;
    logic [2:0] trial_shadow;
    logic       busy_shadow;
    result_t    predicted_words[$];

    function automatic result_t next_conversion_word(input item_t w);
        result_t r;
        logic    done;
        logic    manual;
        logic [2:0] idx;
        done = 1'b0;
        manual = 1'b0;
        if (w.action == ACT_START)
        begin
            case (mode_shadow)
                MODE_MANUAL:
                begin
                    code_shadow = ~w.switch_byte;
                    busy_shadow = 1'b0;
                    done = 1'b1;
                    manual = 1'b1;
                end
                MODE_TRACK:
                begin
                    code_shadow = TRACK_FIRST;
                    trial_shadow = '0;
                    busy_shadow = 1'b1;
                end
                MODE_SAR:
                begin
                    trial_shadow = TOP_TRIAL;
                    code_shadow = SAR_FIRST;
                    busy_shadow = 1'b1;
                end
                default: ;
            endcase
        end
        else if (busy_shadow)
        begin
            case (mode_shadow)
                MODE_TRACK:
                begin
                    if (w.comparator_high)
                    begin
                        code_shadow = code_shadow - 8'd1;
                        busy_shadow = 1'b0;
                        done = 1'b1;
                    end
                    else if (code_shadow == CODE_FULL)
                    begin
                        busy_shadow = 1'b0;
                        done = 1'b1;
                    end
                    else
                    begin
                        code_shadow = code_shadow + 8'd1;
                    end
                end
                MODE_SAR:
                begin
                    idx = trial_shadow;
                    if (w.comparator_high)
                        code_shadow[idx] = 1'b0;
                    if (idx == 3'd0)
                    begin
                        busy_shadow = 1'b0;
                        done = 1'b1;
                    end
                    else
                    begin
                        trial_shadow = idx - 3'd1;
                        code_shadow[trial_shadow] = 1'b1;
                    end
                end
                default: busy_shadow = 1'b0;
            endcase
        end
        r.dac_code = code_shadow;
        r.led_pattern = manual ? w.switch_byte : ~code_shadow;
        r.busy_res = busy_shadow;
        r.conversion_done = done;
        return r;
    endfunction

    task automatic check_field(input string label, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, actual %0h", $time, label, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        item_t   w;
        result_t want;
        if (!rst_n)
        begin
            mode_shadow = MODE_RESET;
            code_shadow = '0;
            trial_shadow = '0;
            busy_shadow = 1'b0;
            predicted_words.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == MODE_ADDR)
                mode_shadow = mode_t'(pwdata[1:0]);

            if (out_mon.valid && out_mon.ready)
            begin
                if (predicted_words.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected word, expected none, actual %0h %0h %0b %0b",
                             $time, out_mon.dac_code, out_mon.led_pattern,
                             out_mon.busy_res, out_mon.conversion_done);
                end
                else
                begin
                    want = predicted_words.pop_front();
                    check_field("dac_code", want.dac_code, out_mon.dac_code);
                    check_field("led_pattern", want.led_pattern, out_mon.led_pattern);
                    check_field("busy_res", want.busy_res, out_mon.busy_res);
                    check_field("conversion_done", want.conversion_done,
                                out_mon.conversion_done);
                end
            end

            if (in_mon.valid && in_mon.ready)
            begin
                w.action = in_mon.action;
                w.comparator_high = in_mon.comparator_high;
                w.switch_byte = in_mon.switch_byte;
                predicted_words.push_back(next_conversion_word(w));
            end

            outstanding <= predicted_words.size();
        end
    end

endmodule

// File: bench/tb_adc_conversion_controller.sv
`timescale 1ns / 100ps

module tb_adc_conversion_controller;
    import adcc_pkg::*;

    localparam logic [PADDR_W-1:0] MODE_ADDR   = PADDR_W'(4 * REG_MODE);
    localparam mode_t              MODE_UNUSED = 2'd3;
    localparam int                 TOTAL_WORDS = 500;
    localparam int                 HOLD_CYCLES = 150;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int mismatches;
    int outstanding;
    int hold_req = 0;
    int words_sent = 0;
    bit idle_on = 1'b1;
    bit sender_gaps = 1'b1;
    bit ramp_pending = 1'b1;

    adcc_in_if  in_ch();
    adcc_out_if out_ch();

    adc_conversion_controller uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    adcc_result_checker result_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #3_600_000;
        $display("status: fail");
        $finish;
    end

    // receiver: random stall bursts, plus a long hold on request
    initial
    begin
        int stall_left;
        int hold_seen;
        stall_left = 0;
        hold_seen = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 11);
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    function automatic item_t make_item(input logic act, input logic comp,
                                        input logic [7:0] sw);
        item_t w;
        w.action = act;
        w.comparator_high = comp;
        w.switch_byte = sw;
        return w;
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic any_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic send_word(input item_t w);
        if (sender_gaps && idle_on && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= w.action;
        in_ch.comparator_high <= w.comparator_high;
        in_ch.switch_byte <= w.switch_byte;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_mode(input logic [PDATA_W-1:0] value);
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MODE_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic run_conversion(input mode_t m);
        int steps;
        int trip_at;
        if ($urandom_range(0, 9) == 0)
        begin
            send_word(make_item(any_bit(), any_bit(), any_byte()));
        end
        else
        begin
            case (m)
                MODE_MANUAL:
                begin
                    send_word(make_item(ACT_START, any_bit(), any_byte()));
                    if ($urandom_range(0, 3) == 0)
                        send_word(make_item(ACT_SAMPLE, any_bit(), any_byte()));
                end
                MODE_TRACK:
                begin
                    if (ramp_pending)
                    begin
                        ramp_pending = 1'b0;
                        steps = 256;
                        trip_at = -1;
                    end
                    else
                    begin
                        steps = $urandom_range(1, 30);
                        trip_at = ($urandom_range(0, 7) == 0) ? -1 : steps;
                    end
                    send_word(make_item(ACT_START, any_bit(), any_byte()));
                    for (int i = 1; i <= steps; i++)
                        send_word(make_item(ACT_SAMPLE, i == trip_at, any_byte()));
                end
                MODE_SAR:
                begin
                    steps = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : 8;
                    send_word(make_item(ACT_START, any_bit(), any_byte()));
                    for (int i = 0; i < steps; i++)
                        send_word(make_item(ACT_SAMPLE, any_bit(), any_byte()));
                end
                default:
                begin
                    steps = $urandom_range(1, 4);
                    for (int i = 0; i < steps; i++)
                        send_word(make_item(any_bit(), any_bit(), any_byte()));
                end
            endcase
        end
    endtask

    initial
    begin
        int            phase;
        int            count;
        mode_t         m;
        logic [PDATA_W-1:0] cfg;

        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.action <= ACT_START;
        in_ch.comparator_high <= 1'b0;
        in_ch.switch_byte <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sample while idle, then a full approximation in the reset mode
        send_word(make_item(ACT_SAMPLE, 1'b1, 8'hFF));
        send_word(make_item(ACT_START, 1'b0, 8'hAA));
        for (int i = 0; i < 8; i++)
            send_word(make_item(ACT_SAMPLE, 1'(i), 8'h00));

        set_mode(PDATA_W'(MODE_MANUAL));
        send_word(make_item(ACT_START, 1'b0, 8'h00));
        send_word(make_item(ACT_START, 1'b1, 8'hFF));

        set_mode({{(PDATA_W - 2){1'b1}}, MODE_TRACK});
        send_word(make_item(ACT_START, 1'b0, 8'h00));
        send_word(make_item(ACT_SAMPLE, 1'b0, 8'h00));
        send_word(make_item(ACT_SAMPLE, 1'b1, 8'h00));
        send_word(make_item(ACT_START, 1'b0, 8'h00));
        send_word(make_item(ACT_SAMPLE, 1'b1, 8'h00));

        // mode switched mid-run
        send_word(make_item(ACT_START, 1'b0, 8'h00));
        set_mode(PDATA_W'(MODE_SAR));
        send_word(make_item(ACT_SAMPLE, 1'b0, 8'h00));
        send_word(make_item(ACT_START, 1'b0, 8'h00));
        set_mode(PDATA_W'(MODE_TRACK));
        send_word(make_item(ACT_SAMPLE, 1'b0, 8'h00));
        set_mode(PDATA_W'(MODE_UNUSED));
        send_word(make_item(ACT_START, 1'b0, 8'hFF));
        send_word(make_item(ACT_SAMPLE, 1'b1, 8'h00));
        send_word(make_item(ACT_SAMPLE, 1'b0, 8'h00));
        set_mode(PDATA_W'(MODE_SAR));
        send_word(make_item(ACT_START, 1'b0, 8'h00));
        set_mode(PDATA_W'(MODE_MANUAL));
        send_word(make_item(ACT_SAMPLE, 1'b1, 8'h00));

        phase = 0;
        while (words_sent < TOTAL_WORDS)
        begin
            if (words_sent >= TOTAL_WORDS - 60)
                idle_on <= 1'b0;
            case ($urandom_range(0, 9))
                0:       m = MODE_MANUAL;
                1:       m = MODE_UNUSED;
                2, 3, 4: m = MODE_TRACK;
                default: m = MODE_SAR;
            endcase
            if (phase == 0)
                m = MODE_TRACK;
            if (phase == 2)
                m = MODE_SAR;
            cfg = $urandom();
            cfg[1:0] = m;
            set_mode(cfg);
            count = $urandom_range(2, 6);
            if (phase == 2)
            begin
                hold_req <= hold_req + 1;
                sender_gaps = 1'b0;
                count = 4;
            end
            for (int i = 0; i < count && words_sent < TOTAL_WORDS; i++)
                run_conversion(m);
            sender_gaps = 1'b1;
            phase++;
        end

        wait_drained();
        repeat (12) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
